>>> rtl/distance_vector_route_table_core_macros.svh
// Assertion helpers shared by the RTL of the route table core.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_CORE_MACROS_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DVRT_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DVRT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/dvrt_pkg.sv
package dvrt_pkg;

    localparam int NUM_NODES   = 16;
    localparam int IDX_W       = $clog2(NUM_NODES);
    localparam int NODE_W      = 4;
    localparam int COST_W      = 27;
    localparam int WIDE_W      = NODE_W + IDX_W;
    localparam int MAX_RESULTS = 16;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

    localparam logic [COST_W-1:0] INF_COST = COST_W'(100000000);

    localparam logic [2:0] ACT_LINK    = 3'd0;
    localparam logic [2:0] ACT_UNKNOWN = 3'd1;
    localparam logic [2:0] ACT_COST    = 3'd2;
    localparam logic [2:0] ACT_VEC     = 3'd3;
    localparam logic [2:0] ACT_VEND    = 3'd4;
    localparam logic [2:0] ACT_FWD     = 3'd5;
    localparam logic [2:0] ACT_ADV     = 3'd6;

    localparam logic [1:0] KIND_LOCAL  = 2'd0;
    localparam logic [1:0] KIND_FWD    = 2'd1;
    localparam logic [1:0] KIND_UNREACH = 2'd2;
    localparam logic [1:0] KIND_ADV    = 2'd3;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [NODE_W-1:0] t_node;
    typedef logic [COST_W-1:0] t_cost;
    typedef logic [WIDE_W-1:0] t_wide;

    // operands and results of the shared cost unit
    typedef struct packed {
        t_cost x;
        t_cost y;
    } t_cu_req;

    typedef struct packed {
        t_cost sum;
        logic  gt;
    } t_cu_rsp;

    function automatic t_wide wide_node(input t_node n);
        return {{IDX_W{1'b0}}, n};
    endfunction

    function automatic t_wide wide_idx(input t_idx i);
        return {{NODE_W{1'b0}}, i};
    endfunction

    function automatic t_idx node_to_idx(input t_node n);
        t_wide w;
        w = wide_node(n);
        return w[IDX_W-1:0];
    endfunction

    function automatic t_node idx_to_node(input t_idx i);
        t_wide w;
        w = wide_idx(i);
        return w[NODE_W-1:0];
    endfunction

    function automatic logic in_range(input t_node n);
        return wide_node(n) < WIDE_W'(NUM_NODES);
    endfunction

    function automatic logic usable(input t_node n, input t_node me);
        return in_range(n) && (n != me);
    endfunction

endpackage

>>> rtl/dvrt_ram.sv
module dvrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/dvrt_cost_unit.sv
module dvrt_cost_unit
    import dvrt_pkg::*;
(
    input  t_cu_req i_req,
    output t_cu_rsp o_rsp
);

    logic [COST_W:0] raw_sum;

    // saturating add and magnitude compare, shared by every action
    assign raw_sum   = {1'b0, i_req.x} + {1'b0, i_req.y};
    assign o_rsp.sum = (raw_sum > {1'b0, INF_COST}) ? INF_COST : raw_sum[COST_W-1:0];
    assign o_rsp.gt  = i_req.x > i_req.y;

endmodule

>>> rtl/distance_vector_route_table_core.sv
// Load link to this router writes in decode; other load link and load unknown mark end a, then
// end b; cost change reads, then checks; vector entry reads sender, destination, then writes;
// vector end and advertise walk the table. Forward and advertise results appear in the cycle
// after the state that forms them. One transaction runs at a time: every step shares one read
// port of the table RAMs and one saturating add/compare unit. Results strobe for one cycle only.
// Synchronous active-low reset clears my_id, the table valid marks and the sequencer.
`include "distance_vector_route_table_core_macros.svh"

module distance_vector_route_table_core
    import dvrt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_action,
    input  logic [3:0]  i_node_a,
    input  logic [3:0]  i_node_b,
    input  logic [26:0] i_cost,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_next_hop,
    output logic [3:0]  o_dest,
    output logic [26:0] o_entry_cost,
    output logic        o_last
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DEC    = 4'd1;
    localparam logic [3:0] S_MARK_B = 4'd2;
    localparam logic [3:0] S_CC_CHK = 4'd3;
    localparam logic [3:0] S_VE_A   = 4'd4;
    localparam logic [3:0] S_VE_B   = 4'd5;
    localparam logic [3:0] S_VE_WR  = 4'd6;
    localparam logic [3:0] S_VD_RD  = 4'd7;
    localparam logic [3:0] S_VD_WR  = 4'd8;
    localparam logic [3:0] S_FW     = 4'd9;
    localparam logic [3:0] S_AD_RD  = 4'd10;
    localparam logic [3:0] S_AD_CK  = 4'd11;
    localparam logic [3:0] S_AD_FL  = 4'd12;

    localparam t_idx LAST_IDX = IDX_W'(NUM_NODES - 1);

    logic [3:0]           r_state, n_state;
    t_node                r_my_id;
    t_idx                 r_i, n_i;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_pend, n_pend;
    t_idx                 r_pend_hop, n_pend_hop;
    t_idx                 r_pend_dest, n_pend_dest;
    t_cost                r_pend_cost, n_pend_cost;
    logic [2:0]           r_act, n_act;
    t_node                r_a, n_a;
    t_node                r_b, n_b;
    t_cost                r_c, n_c;
    t_cost                r_ca, n_ca;
    t_idx                 r_ha, n_ha;
    t_cost                r_cb, n_cb;
    t_idx                 r_hb, n_hb;
    t_cost                r_sum, n_sum;
    logic                 r_out_valid, n_out_valid;
    logic [1:0]           r_out_kind, n_out_kind;
    t_node                r_out_hop, n_out_hop;
    t_node                r_out_dest, n_out_dest;
    t_cost                r_out_cost, n_out_cost;
    logic                 r_out_last, n_out_last;

    // written marks; an unmarked entry reads as its reset value
    logic [NUM_NODES-1:0] r_rc_wr;
    logic [NUM_NODES-1:0] r_rh_wr;
    logic [NUM_NODES-1:0] r_hv;
    logic [NUM_NODES-1:0] r_nb;

    t_idx    rd_idx;
    t_idx    r_rd_idx;
    t_idx    waddr;
    logic    rc_we, rh_we, lc_we, hv_we, hv_wdata;
    t_cost   rc_wdata, lc_wdata;
    t_idx    rh_wdata;
    t_cost   rc_q, lc_q;
    t_idx    rh_q;
    t_cost   cost_rd, link_rd;
    t_idx    hop_rd;
    t_cu_req cu_req;
    t_cu_rsp cu_rsp;
    t_node   tgt;
    t_idx    tgt_idx, a_idx, b_idx;

    dvrt_ram #(.WIDTH(COST_W), .DEPTH(NUM_NODES)) u_route_cost (
        .i_clk  (i_clk),
        .i_we   (rc_we),
        .i_waddr(waddr),
        .i_wdata(rc_wdata),
        .i_raddr(rd_idx),
        .o_rdata(rc_q)
    );

    dvrt_ram #(.WIDTH(IDX_W), .DEPTH(NUM_NODES)) u_route_hop (
        .i_clk  (i_clk),
        .i_we   (rh_we),
        .i_waddr(waddr),
        .i_wdata(rh_wdata),
        .i_raddr(rd_idx),
        .o_rdata(rh_q)
    );

    dvrt_ram #(.WIDTH(COST_W), .DEPTH(NUM_NODES)) u_link_cost (
        .i_clk  (i_clk),
        .i_we   (lc_we),
        .i_waddr(waddr),
        .i_wdata(lc_wdata),
        .i_raddr(rd_idx),
        .o_rdata(lc_q)
    );

    dvrt_cost_unit u_cost_unit (
        .i_req(cu_req),
        .o_rsp(cu_rsp)
    );

    assign cost_rd = r_rc_wr[r_rd_idx] ? rc_q : INF_COST;
    assign hop_rd  = r_rh_wr[r_rd_idx] ? rh_q : '0;
    assign link_rd = r_nb[r_rd_idx] ? lc_q : INF_COST;

    // link end that is not this router
    assign tgt     = (r_a == r_my_id) ? r_b : r_a;
    assign tgt_idx = node_to_idx(tgt);
    assign a_idx   = node_to_idx(r_a);
    assign b_idx   = node_to_idx(r_b);

    always_comb begin
        n_state     = r_state;
        n_i         = r_i;
        n_cnt       = r_cnt;
        n_pend      = r_pend;
        n_pend_hop  = r_pend_hop;
        n_pend_dest = r_pend_dest;
        n_pend_cost = r_pend_cost;
        n_act       = r_act;
        n_a         = r_a;
        n_b         = r_b;
        n_c         = r_c;
        n_ca        = r_ca;
        n_ha        = r_ha;
        n_cb        = r_cb;
        n_hb        = r_hb;
        n_sum       = r_sum;
        n_out_valid = 1'b0;
        n_out_kind  = r_out_kind;
        n_out_hop   = r_out_hop;
        n_out_dest  = r_out_dest;
        n_out_cost  = r_out_cost;
        n_out_last  = r_out_last;
        rd_idx      = r_i;
        waddr       = tgt_idx;
        rc_we       = 1'b0;
        rc_wdata    = INF_COST;
        rh_we       = 1'b0;
        rh_wdata    = tgt_idx;
        lc_we       = 1'b0;
        lc_wdata    = r_c;
        hv_we       = 1'b0;
        hv_wdata    = 1'b0;
        cu_req.x    = cost_rd;
        cu_req.y    = r_c;

        unique case (r_state)
            S_IDLE: begin
                // clamp the incoming cost through the shared unit
                cu_req.x = i_cost;
                cu_req.y = '0;
                if (start) begin
                    n_act   = i_action;
                    n_a     = i_node_a;
                    n_b     = i_node_b;
                    n_c     = cu_rsp.sum;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_state = S_IDLE;
                unique case (r_act) inside
                    ACT_LINK, ACT_UNKNOWN: begin
                        if (r_act == ACT_LINK && (r_a == r_my_id || r_b == r_my_id)) begin
                            if (usable(tgt, r_my_id)) begin
                                rc_we    = 1'b1;
                                rc_wdata = r_c;
                                rh_we    = 1'b1;
                                hv_we    = 1'b1;
                                hv_wdata = 1'b1;
                                lc_we    = 1'b1;
                            end
                        end else begin
                            waddr = a_idx;
                            if (usable(r_a, r_my_id) && !r_nb[a_idx]) begin
                                rc_we = 1'b1;
                                hv_we = 1'b1;
                            end
                            n_state = S_MARK_B;
                        end
                    end
                    ACT_COST: begin
                        rd_idx = tgt_idx;
                        if (usable(tgt, r_my_id)) begin
                            n_state = S_CC_CHK;
                        end
                    end
                    ACT_VEC: begin
                        rd_idx = a_idx;
                        if (usable(r_b, r_my_id) && in_range(r_a)) begin
                            n_state = S_VE_A;
                        end
                    end
                    ACT_VEND: begin
                        n_i     = '0;
                        n_state = S_VD_RD;
                    end
                    ACT_FWD: begin
                        rd_idx  = b_idx;
                        n_state = S_FW;
                    end
                    ACT_ADV: begin
                        n_i     = '0;
                        n_cnt   = '0;
                        n_pend  = 1'b0;
                        n_state = S_AD_RD;
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            S_MARK_B: begin
                waddr = b_idx;
                if (usable(r_b, r_my_id) && !r_nb[b_idx]) begin
                    rc_we = 1'b1;
                    hv_we = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_CC_CHK: begin
                lc_we = 1'b1;
                if (r_hv[tgt_idx] && hop_rd == tgt_idx) begin
                    rc_we    = 1'b1;
                    rc_wdata = r_c;
                end else if (cu_rsp.gt) begin
                    rc_we    = 1'b1;
                    rc_wdata = r_c;
                    rh_we    = 1'b1;
                    hv_we    = 1'b1;
                    hv_wdata = 1'b1;
                end
                n_state = S_IDLE;
            end
            S_VE_A: begin
                n_ca    = cost_rd;
                n_ha    = hop_rd;
                rd_idx  = b_idx;
                n_state = S_VE_B;
            end
            S_VE_B: begin
                cu_req.x = r_ca;
                n_sum    = cu_rsp.sum;
                n_cb     = cost_rd;
                n_hb     = hop_rd;
                n_state  = S_VE_WR;
            end
            S_VE_WR: begin
                waddr    = b_idx;
                rc_wdata = r_sum;
                cu_req.x = r_cb;
                cu_req.y = r_sum;
                if (r_hv[b_idx] && r_hb == a_idx) begin
                    // route already runs via the sender: follow its cost
                    rc_we = 1'b1;
                end else if (cu_rsp.gt) begin
                    rc_we    = 1'b1;
                    rh_we    = 1'b1;
                    rh_wdata = r_ha;
                    hv_we    = 1'b1;
                    hv_wdata = r_hv[a_idx];
                end
                n_state = S_IDLE;
            end
            S_VD_RD: begin
                rd_idx  = r_i;
                n_state = S_VD_WR;
            end
            S_VD_WR: begin
                waddr    = r_i;
                cu_req.y = link_rd;
                rc_wdata = link_rd;
                if (r_nb[r_i] && cu_rsp.gt) begin
                    rc_we = 1'b1;
                end
                if (r_i == LAST_IDX) begin
                    n_state = S_IDLE;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_VD_RD;
                end
            end
            S_FW: begin
                cu_req.x    = INF_COST;
                cu_req.y    = cost_rd;
                n_out_valid = 1'b1;
                n_out_dest  = r_b;
                n_out_cost  = '0;
                n_out_last  = 1'b0;
                n_out_hop   = '0;
                if (r_b == r_my_id) begin
                    n_out_kind = KIND_LOCAL;
                end else if (in_range(r_b) && cu_rsp.gt) begin
                    n_out_kind = KIND_FWD;
                    n_out_hop  = idx_to_node(hop_rd);
                end else begin
                    n_out_kind = KIND_UNREACH;
                end
                n_state = S_IDLE;
            end
            S_AD_RD: begin
                rd_idx = r_i;
                if (wide_idx(r_i) != wide_node(r_my_id) && r_hv[r_i]) begin
                    n_state = S_AD_CK;
                end else if (r_i == LAST_IDX) begin
                    n_state = S_AD_FL;
                end else begin
                    n_i = r_i + IDX_W'(1);
                end
            end
            S_AD_CK: begin
                // hold one entry back so the final one can carry last
                if (r_pend) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_ADV;
                    n_out_hop   = idx_to_node(r_pend_hop);
                    n_out_dest  = idx_to_node(r_pend_dest);
                    n_out_cost  = r_pend_cost;
                    n_out_last  = 1'b0;
                end
                n_pend      = 1'b1;
                n_pend_hop  = hop_rd;
                n_pend_dest = r_i;
                n_pend_cost = cost_rd;
                n_cnt       = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MAX_RESULTS - 1) || r_i == LAST_IDX) begin
                    n_state = S_AD_FL;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = S_AD_RD;
                end
            end
            S_AD_FL: begin
                if (r_pend) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = KIND_ADV;
                    n_out_hop   = idx_to_node(r_pend_hop);
                    n_out_dest  = idx_to_node(r_pend_dest);
                    n_out_cost  = r_pend_cost;
                    n_out_last  = 1'b1;
                end
                n_pend  = 1'b0;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_my_id     <= '0;
            r_i         <= '0;
            r_cnt       <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_rc_wr     <= '0;
            r_rh_wr     <= '0;
            r_hv        <= '0;
            r_nb        <= '0;
        end else begin
            r_state     <= n_state;
            r_i         <= n_i;
            r_cnt       <= n_cnt;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_my_id <= i_cfg_wdata;
            end
            if (rc_we) begin
                r_rc_wr[waddr] <= 1'b1;
            end
            if (rh_we) begin
                r_rh_wr[waddr] <= 1'b1;
            end
            if (hv_we) begin
                r_hv[waddr] <= hv_wdata;
            end
            if (lc_we) begin
                r_nb[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= rd_idx;
        r_pend_hop  <= n_pend_hop;
        r_pend_dest <= n_pend_dest;
        r_pend_cost <= n_pend_cost;
        r_act       <= n_act;
        r_a         <= n_a;
        r_b         <= n_b;
        r_c         <= n_c;
        r_ca        <= n_ca;
        r_ha        <= n_ha;
        r_cb        <= n_cb;
        r_hb        <= n_hb;
        r_sum       <= n_sum;
        r_out_kind  <= n_out_kind;
        r_out_hop   <= n_out_hop;
        r_out_dest  <= n_out_dest;
        r_out_cost  <= n_out_cost;
        r_out_last  <= n_out_last;
    end

    assign busy         = r_state != S_IDLE;
    assign o_valid      = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_next_hop   = r_out_hop;
    assign o_dest       = r_out_dest;
    assign o_entry_cost = r_out_cost;
    assign o_last       = r_out_last;

    `DVRT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accepted transaction left busy low")
    `DVRT_ASSERT_NOW(a_result_active, i_clk, i_rst_n, o_valid, $past(r_state) != S_IDLE, "result strobe without an active transaction")
    `DVRT_ASSERT_NOW(a_last_kind, i_clk, i_rst_n, o_valid && o_last, o_kind == KIND_ADV, "last flag on a non-advertised result")
    `DVRT_ASSERT_NOW(a_cnt_bound, i_clk, i_rst_n, r_state == S_AD_RD || r_state == S_AD_CK, r_cnt < CNT_W'(MAX_RESULTS), "advertise run overran its result limit")

endmodule

>>> tb/distance_vector_route_table_core_tb.sv
`timescale 1ns / 100ps

module distance_vector_route_table_core_tb;
    import dvrt_pkg::*;

    localparam logic [2:0] ACT_SPARE     = 3'd7;
    localparam int         MAX_GAP       = 17;
    localparam int         SETTLE_CYCLES = 2 * NUM_NODES + 8;
    localparam int         PHASE_ITEMS   = 37;

    typedef enum logic [1:0] {STEP_ITEM, STEP_CFG, STEP_DRAIN} t_step;

    typedef struct {
        t_step      op;
        logic [2:0] action;
        t_node      a;
        t_node      b;
        t_cost      cost;
    } t_plan_step;

    typedef struct {
        logic [1:0] kind;
        t_node      hop;
        t_node      dest;
        t_cost      cost;
        logic       last;
    } t_route_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [3:0]  i_cfg_wdata = '0;
    logic        start       = 1'b0;
    logic        busy;
    logic [2:0]  i_action    = '0;
    logic [3:0]  i_node_a    = '0;
    logic [3:0]  i_node_b    = '0;
    logic [26:0] i_cost      = '0;
    logic        o_valid;
    logic [1:0]  o_kind;
    logic [3:0]  o_next_hop;
    logic [3:0]  o_dest;
    logic [26:0] o_entry_cost;
    logic        o_last;

    t_plan_step    plan_q[$];
    t_route_result pending_results[$];
    t_plan_step    cur_step;
    bit            holding    = 1'b0;
    bit            no_gaps    = 1'b0;
    int            gap_cnt    = 0;
    int            settle_cnt = 0;
    int            mismatch_cnt = 0;

    // shadow of the routing table
    t_cost tbl_cost [NUM_NODES];
    t_node tbl_hop  [NUM_NODES];
    bit    tbl_valid[NUM_NODES];
    t_cost tbl_link [NUM_NODES];
    bit    tbl_nb   [NUM_NODES];
    t_node self_id;

    distance_vector_route_table_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .start       (start),
        .busy        (busy),
        .i_action    (i_action),
        .i_node_a    (i_node_a),
        .i_node_b    (i_node_b),
        .i_cost      (i_cost),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_next_hop  (o_next_hop),
        .o_dest      (o_dest),
        .o_entry_cost(o_entry_cost),
        .o_last      (o_last)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_cost sat_cost(input logic [COST_W:0] c);
        return (c > {1'b0, INF_COST}) ? INF_COST : c[COST_W-1:0];
    endfunction

    task automatic queue_result(input logic [1:0] kind, input t_node hop, input t_node dest,
                                input t_cost cost, input logic last);
        t_route_result r;
        r.kind = kind;
        r.hop  = hop;
        r.dest = dest;
        r.cost = cost;
        r.last = last;
        pending_results = {pending_results, r};
    endtask

    // every 4-bit index is inside the table, so only the own entry is barred
    task automatic make_direct(input t_node n, input t_cost c);
        if (n != self_id) begin
            tbl_cost[n]  = c;
            tbl_hop[n]   = n;
            tbl_valid[n] = 1'b1;
            tbl_link[n]  = c;
            tbl_nb[n]    = 1'b1;
        end
    endtask

    task automatic forget_route(input t_node n);
        if (n != self_id && !tbl_nb[n]) begin
            tbl_cost[n]  = INF_COST;
            tbl_valid[n] = 1'b0;
        end
    endtask

    task automatic route_table_step(input t_plan_step s);
        t_cost c;
        t_cost sum;
        t_node tgt;
        int    last_idx;
        c = sat_cost({1'b0, s.cost});
        case (s.action)
            ACT_LINK: begin
                if (s.a == self_id)
                    make_direct(s.b, c);
                else if (s.b == self_id)
                    make_direct(s.a, c);
                else begin
                    forget_route(s.a);
                    forget_route(s.b);
                end
            end
            ACT_UNKNOWN: begin
                forget_route(s.a);
                forget_route(s.b);
            end
            ACT_COST: begin
                tgt = (s.a == self_id) ? s.b : s.a;
                if (tgt != self_id) begin
                    tbl_link[tgt] = c;
                    tbl_nb[tgt]   = 1'b1;
                    if (tbl_valid[tgt] && tbl_hop[tgt] == tgt) begin
                        tbl_cost[tgt] = c;
                    end else if (tbl_cost[tgt] > c) begin
                        tbl_cost[tgt]  = c;
                        tbl_hop[tgt]   = tgt;
                        tbl_valid[tgt] = 1'b1;
                    end
                end
            end
            ACT_VEC: begin
                if (s.b != self_id) begin
                    sum = sat_cost({1'b0, tbl_cost[s.a]} + {1'b0, c});
                    if (tbl_valid[s.b] && tbl_hop[s.b] == s.a)
                        tbl_cost[s.b] = sum;
                    // sender and destination may be the same entry: take the sum again
                    sum = sat_cost({1'b0, tbl_cost[s.a]} + {1'b0, c});
                    if (tbl_cost[s.b] > sum) begin
                        tbl_cost[s.b]  = sum;
                        tbl_hop[s.b]   = tbl_hop[s.a];
                        tbl_valid[s.b] = tbl_valid[s.a];
                    end
                end
            end
            ACT_VEND: begin
                for (int i = 0; i < NUM_NODES; i++)
                    if (tbl_nb[i] && tbl_cost[i] > tbl_link[i])
                        tbl_cost[i] = tbl_link[i];
            end
            ACT_FWD: begin
                if (s.b == self_id)
                    queue_result(KIND_LOCAL, '0, s.b, '0, 1'b0);
                else if (tbl_cost[s.b] != INF_COST)
                    queue_result(KIND_FWD, tbl_hop[s.b], s.b, '0, 1'b0);
                else
                    queue_result(KIND_UNREACH, '0, s.b, '0, 1'b0);
            end
            ACT_ADV: begin
                last_idx = -1;
                for (int i = 0; i < NUM_NODES; i++)
                    if (t_node'(i) != self_id && tbl_valid[i])
                        last_idx = i;
                for (int i = 0; i < NUM_NODES; i++)
                    if (t_node'(i) != self_id && tbl_valid[i])
                        queue_result(KIND_ADV, tbl_hop[i], t_node'(i), tbl_cost[i],
                                     i == last_idx);
            end
            default: begin
            end
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
        mismatch_cnt++;
    endtask

    task automatic add_item(input logic [2:0] act, input t_node a, input t_node b,
                            input t_cost c);
        t_plan_step s;
        s.op     = STEP_ITEM;
        s.action = act;
        s.a      = a;
        s.b      = b;
        s.cost   = c;
        plan_q   = {plan_q, s};
    endtask

    task automatic add_control(input t_step op, input t_node id);
        t_plan_step s;
        s.op     = op;
        s.action = ACT_SPARE;
        s.a      = id;
        s.b      = '0;
        s.cost   = '0;
        plan_q   = {plan_q, s};
    endtask

    function automatic t_node pick_node();
        return t_node'($urandom_range(0, NUM_NODES - 1));
    endfunction

    function automatic t_cost pick_cost();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return INF_COST;
            2:       return '1;
            3:       return t_cost'($urandom);
            4:       return INF_COST - t_cost'($urandom_range(0, 50));
            default: return t_cost'($urandom_range(1, 200));
        endcase
    endfunction

    // links first, then mostly advertised vectors closed by their end marker
    task automatic add_route_phase(input t_node me);
        int    made;
        int    k;
        t_node s;
        made = 0;
        repeat (3) begin
            s = pick_node();
            if ($urandom_range(0, 1))
                add_item(ACT_LINK, me, s, t_cost'($urandom_range(1, 60)));
            else
                add_item(ACT_LINK, s, me, t_cost'($urandom_range(1, 60)));
            made++;
        end
        while (made < PHASE_ITEMS) begin
            case ($urandom_range(0, 11))
                0, 1, 2, 3: begin
                    s = pick_node();
                    k = $urandom_range(2, 5);
                    repeat (k) add_item(ACT_VEC, s, pick_node(), pick_cost());
                    add_item(ACT_VEND, pick_node(), pick_node(), pick_cost());
                    made += k + 1;
                end
                4, 5: begin
                    add_item(ACT_FWD, pick_node(), pick_node(), pick_cost());
                    made++;
                end
                6: begin
                    add_item(ACT_ADV, pick_node(), pick_node(), pick_cost());
                    made++;
                end
                7: begin
                    if ($urandom_range(0, 1))
                        add_item(ACT_COST, me, pick_node(), pick_cost());
                    else
                        add_item(ACT_COST, pick_node(), me, pick_cost());
                    made++;
                end
                8: begin
                    add_item(ACT_UNKNOWN, pick_node(), pick_node(), pick_cost());
                    made++;
                end
                9: begin
                    add_item(ACT_LINK, me, pick_node(), pick_cost());
                    made++;
                end
                default: begin
                    add_item(3'($urandom_range(0, 7)), pick_node(), pick_node(),
                             t_cost'($urandom));
                    made++;
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin : drive_proc
        bit         we_nxt;
        logic [3:0] wdata_nxt;
        t_plan_step spent;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cfg_we <= 1'b0;
        end else begin
            we_nxt    = 1'b0;
            wdata_nxt = i_cfg_wdata;
            if (holding && start && !busy) begin
                route_table_step(cur_step);
                holding = 1'b0;
                if ($urandom_range(0, 15) == 0)
                    no_gaps = !no_gaps;
                gap_cnt = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (!holding && plan_q.size() > 0) begin
                case (plan_q[0].op)
                    STEP_ITEM: begin
                        if (gap_cnt > 0) begin
                            gap_cnt--;
                        end else begin
                            cur_step = plan_q.pop_front();
                            holding  = 1'b1;
                        end
                    end
                    STEP_CFG: begin
                        spent     = plan_q.pop_front();
                        we_nxt    = 1'b1;
                        wdata_nxt = spent.a;
                        self_id   = spent.a;
                    end
                    default: begin
                        // hold until the table is quiet, then let the sequencer settle
                        if (pending_results.size() == 0 && !busy) begin
                            if (settle_cnt >= SETTLE_CYCLES) begin
                                settle_cnt = 0;
                                spent      = plan_q.pop_front();
                            end else begin
                                settle_cnt++;
                            end
                        end else begin
                            settle_cnt = 0;
                        end
                    end
                endcase
            end
            start       <= holding;
            i_cfg_we    <= we_nxt;
            i_cfg_wdata <= wdata_nxt;
            i_action    <= cur_step.action;
            i_node_a    <= cur_step.a;
            i_node_b    <= cur_step.b;
            i_cost      <= cur_step.cost;
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_route_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no transaction pending", o_dest, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_kind !== want.kind)
                    report_mismatch("kind", o_kind, want.kind);
                if (o_next_hop !== want.hop)
                    report_mismatch("next_hop", o_next_hop, want.hop);
                if (o_dest !== want.dest)
                    report_mismatch("dest", o_dest, want.dest);
                if (o_entry_cost !== want.cost)
                    report_mismatch("entry_cost", o_entry_cost, want.cost);
                if (o_last !== want.last)
                    report_mismatch("last", o_last, want.last);
            end
        end
    end

    initial begin : stim_proc
        for (int i = 0; i < NUM_NODES; i++) begin
            tbl_cost[i]  = INF_COST;
            tbl_hop[i]   = '0;
            tbl_valid[i] = 1'b0;
            tbl_link[i]  = INF_COST;
            tbl_nb[i]    = 1'b0;
        end
        self_id = '0;

        // own id at its reset value, empty table
        add_item(ACT_FWD,   4'd3, 4'd0, '0);
        add_item(ACT_FWD,   4'd0, 4'd3, '0);
        add_item(ACT_ADV,   4'd0, 4'd0, '0);
        add_item(ACT_SPARE, 4'd15, 4'd15, '1);

        add_control(STEP_DRAIN, '0);
        add_control(STEP_CFG, 4'd5);
        add_item(ACT_LINK,    4'd5,  4'd1,  27'd10);
        add_item(ACT_LINK,    4'd2,  4'd5,  '0);
        add_item(ACT_LINK,    4'd5,  4'd5,  27'd3);
        add_item(ACT_LINK,    4'd3,  4'd4,  27'd20);
        add_item(ACT_UNKNOWN, 4'd15, 4'd5,  '0);
        add_item(ACT_LINK,    4'd5,  4'd15, '1);
        add_item(ACT_COST,    4'd5,  4'd1,  27'd7);
        add_item(ACT_COST,    4'd2,  4'd9,  27'd3);
        add_item(ACT_COST,    4'd5,  4'd5,  27'd1);
        add_item(ACT_VEC,     4'd1,  4'd7,  27'd4);
        add_item(ACT_VEC,     4'd2,  4'd7,  27'd100);
        add_item(ACT_VEC,     4'd15, 4'd8,  INF_COST - 27'd1);
        add_item(ACT_VEC,     4'd1,  4'd5,  27'd1);
        add_item(ACT_ADV,     4'd0,  4'd0,  '0);
        add_item(ACT_VEC,     4'd1,  4'd7,  INF_COST);
        add_item(ACT_VEND,    4'd0,  4'd0,  '0);
        add_item(ACT_FWD,     4'd0,  4'd5,  '0);
        add_item(ACT_FWD,     4'd0,  4'd7,  '0);
        add_item(ACT_FWD,     4'd0,  4'd15, '0);
        add_item(ACT_COST,    4'd1,  4'd5,  INF_COST);
        add_item(ACT_SPARE,   4'd0,  4'd0,  '0);
        add_item(ACT_ADV,     4'd15, 4'd15, '1);

        add_control(STEP_DRAIN, '0);
        add_control(STEP_CFG, 4'd15);
        add_route_phase(4'd15);
        add_control(STEP_DRAIN, '0);
        add_control(STEP_CFG, 4'd0);
        add_route_phase(4'd0);
        repeat (3) begin
            self_id = pick_node();
            add_control(STEP_DRAIN, '0);
            add_control(STEP_CFG, self_id);
            add_route_phase(self_id);
        end
        self_id = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (plan_q.size() > 0 || holding || pending_results.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("distance_vector_route_table_core_tb: PASS");
        else
            $display("distance_vector_route_table_core_tb: FAIL");
        $finish;
    end

    initial begin : watchdog_proc
        #2_000_000;
        $display("distance_vector_route_table_core_tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
+incdir+rtl
rtl/dvrt_pkg.sv
rtl/dvrt_ram.sv
rtl/dvrt_cost_unit.sv
rtl/distance_vector_route_table_core.sv
tb/distance_vector_route_table_core_tb.sv
